/* hdl/mwsd_pkg.sv */
// Shared widths, types and constants of the multiword short divider.
`timescale 1ns / 1ps

package mwsd_pkg;

	localparam int LIMB_W  = 64;
	localparam int LEN_W   = 9;
	localparam int LEN_MAX = (1 << LEN_W) - 1;
	localparam int STEP_W  = 7;

	typedef logic [LIMB_W-1:0] limb_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [STEP_W-1:0] step_t;

	// Short run: carried remainder already below divisor, only the limb bits go through.
	localparam step_t STEPS_SHORT = step_t'(LIMB_W - 1);
	// Long run: remainder reduced first, both halves go through.
	localparam step_t STEPS_LONG  = step_t'(2 * LIMB_W - 1);

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* hdl/mwsd_req_if.sv */
// Request channel: one dividend limb with its divisor and framing marks.
`timescale 1ns / 1ps

interface mwsd_req_if;
	logic                        valid;
	logic                        ready;
	logic [mwsd_pkg::LIMB_W-1:0] dividend_limb;
	logic [mwsd_pkg::LIMB_W-1:0] divisor_word;
	logic                        first_limb;
	logic                        last_limb;

	modport source (
		output valid, dividend_limb, divisor_word, first_limb, last_limb,
		input  ready
	);
	modport sink (
		input  valid, dividend_limb, divisor_word, first_limb, last_limb,
		output ready
	);
endinterface

/* hdl/mwsd_rsp_if.sv */
// Response channel: one quotient limb plus end-of-number summary.
`timescale 1ns / 1ps

interface mwsd_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [mwsd_pkg::LIMB_W-1:0] quotient_limb;
	logic [mwsd_pkg::LIMB_W-1:0] final_remainder;
	logic                        remainder_nonzero;
	logic [mwsd_pkg::LEN_W-1:0]  quotient_length;
	logic                        is_last;
	logic                        zero_divisor;

	modport source (
		output valid, quotient_limb, final_remainder, remainder_nonzero,
		       quotient_length, is_last, zero_divisor,
		input  ready
	);
	modport sink (
		input  valid, quotient_limb, final_remainder, remainder_nonzero,
		       quotient_length, is_last, zero_divisor,
		output ready
	);
endinterface

/* hdl/mwsd_divider.sv */
// Radix-2 restoring divider, 128-by-64 bits, one shift-subtract step per cycle.
`timescale 1ns / 1ps

module mwsd_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mwsd_pkg::limb_t     hi,
	input  mwsd_pkg::limb_t     lo,
	input  mwsd_pkg::limb_t     d,
	output mwsd_pkg::div_stat_t stat,
	output mwsd_pkg::limb_t     quot,
	output mwsd_pkg::limb_t     rem
);
	import mwsd_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	step_t                 cnt_q;
	limb_t                 r_q;
	limb_t                 d_q;
	limb_t                 q_q;
	logic [2*LIMB_W-1:0]   dvd_q;

	logic [LIMB_W+1:0]     trial;
	logic                  ge;
	limb_t                 r_next;

	// One step: shift next dividend bit into remainder, subtract if it fits.
	assign trial  = {1'b0, r_q, dvd_q[2*LIMB_W-1]} - {2'b00, d_q};
	assign ge     = !trial[LIMB_W+1];
	assign r_next = ge ? trial[LIMB_W-1:0] : {r_q[LIMB_W-2:0], dvd_q[2*LIMB_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= (hi < d) ? STEPS_SHORT : STEPS_LONG;
			end else if (busy_q) begin
				cnt_q <= cnt_q - step_t'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= d;
			q_q <= '0;
			if (hi < d) begin
				r_q   <= hi;
				dvd_q <= {lo, {LIMB_W{1'b0}}};
			end else begin
				r_q   <= '0;
				dvd_q <= {hi, lo};
			end
		end else if (busy_q) begin
			r_q   <= r_next;
			dvd_q <= {dvd_q[2*LIMB_W-2:0], 1'b0};
			q_q   <= {q_q[LIMB_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = q_q;
	assign rem       = r_q;

	// Partial remainder must stay below the divisor for the 66-bit trial to suffice.
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (r_q < d_q))
		else $error("partial remainder not below divisor");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(busy_q) && !busy_q))
		else $error("done without a finished run");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("start while divider busy");

endmodule

/* hdl/multiword_by_word_short_division_unit.sv */
// Top level: multiword by one-word short divider with limb sequencing.
`timescale 1ns / 1ps

// Usage
// req carries one 64-bit dividend limb per request, most significant first,
// with the divisor (held for the whole number), first_limb and last_limb.
// rsp returns one response per limb: the quotient limb at that position; on
// the last limb also the final remainder, its nonzero flag and the count of
// quotient limbs after trimming leading zero limbs.
// After acceptance the divider shifts the limb's bits through, raises its done
// flag, and the sequencer moves to its done state and loads the output
// register, which raises rsp.valid. When the carried remainder is not below
// the divisor (divisor changed mid-number) the divider also runs through the
// upper 64 bits. A zero divisor skips the divider: the sequencer goes straight
// to its done state and answers with zero_divisor set.
// A single shift-subtract unit handles one quotient bit per cycle, and
// req.ready is high only when idle, so a new limb is taken only after the
// last one's result has entered the output register.
// Reset clears the running remainder, counters and all handshakes.
// A stalled rsp holds its response; a finished division waits in the sequencer
// until the output register frees, so no result is dropped.
module multiword_by_word_short_division_unit #(
	parameter int MAX_LIMBS = 256
) (
	input logic clk,
	input logic arst_n,
	mwsd_req_if.sink   req,
	mwsd_rsp_if.source rsp
);
	import mwsd_pkg::*;

	localparam int CNT_W = $clog2(MAX_LIMBS + 1);
	localparam int EXT_W = CNT_W + LEN_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       state_q;
	limb_t            rem_q;       // running remainder
	logic [CNT_W-1:0] count_q;     // significant quotient limbs so far
	logic             seen_q;      // nonzero quotient limb seen
	logic             last_q;
	logic             zero_q;

	logic             rsp_valid_q;
	limb_t            quot_out_q;
	limb_t            rem_out_q;
	logic             rem_nz_q;
	len_t             len_q;
	logic             last_out_q;
	logic             zero_out_q;

	logic             accept;
	logic             start;
	limb_t            hi_in;
	div_stat_t        div_stat;
	limb_t            div_quot;
	limb_t            div_rem;

	logic             out_free;
	logic             load;
	logic             seen_n;
	logic [CNT_W-1:0] cnt_n;
	logic [EXT_W-1:0] cnt_ext;
	len_t             len_n;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign start     = accept && (req.divisor_word != '0);
	// first_limb restarts the number: carried remainder counts as zero
	assign hi_in     = req.first_limb ? '0 : rem_q;

	mwsd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.hi     (hi_in),
		.lo     (req.dividend_limb),
		.d      (req.divisor_word),
		.stat   (div_stat),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// Bookkeeping for the finished limb
	assign out_free = !rsp_valid_q || rsp.ready;
	assign load     = (state_q == ST_DONE) && out_free;
	assign seen_n   = seen_q || (div_quot != '0);
	assign cnt_n    = (seen_n && (count_q < CNT_W'(MAX_LIMBS))) ?
	                  count_q + CNT_W'(1) : count_q;
	assign cnt_ext  = EXT_W'(cnt_n);
	assign len_n    = (cnt_ext > EXT_W'(LEN_MAX)) ? len_t'(LEN_MAX) : cnt_ext[LEN_W-1:0];

	// Sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
			count_q <= '0;
			seen_q  <= 1'b0;
			last_q  <= 1'b0;
			zero_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= req.last_limb;
						zero_q <= !start;
						if (req.first_limb || !start) begin
							rem_q   <= '0;
							count_q <= '0;
							seen_q  <= 1'b0;
						end
						state_q <= start ? ST_RUN : ST_DONE;
					end
				end
				ST_RUN: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (!zero_q) begin
							if (last_q) begin
								rem_q   <= '0;
								count_q <= '0;
								seen_q  <= 1'b0;
							end else begin
								rem_q   <= div_rem;
								count_q <= cnt_n;
								seen_q  <= seen_n;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_out_q <= last_q;
			zero_out_q <= zero_q;
			if (zero_q) begin
				quot_out_q <= '0;
				rem_out_q  <= '0;
				rem_nz_q   <= 1'b0;
				len_q      <= '0;
			end else begin
				quot_out_q <= div_quot;
				rem_out_q  <= last_q ? div_rem : '0;
				rem_nz_q   <= last_q && (div_rem != '0);
				len_q      <= last_q ? len_n : '0;
			end
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.quotient_limb     = quot_out_q;
	assign rsp.final_remainder   = rem_out_q;
	assign rsp.remainder_nonzero = rem_nz_q;
	assign rsp.quotient_length   = len_q;
	assign rsp.is_last           = last_out_q;
	assign rsp.zero_divisor      = zero_out_q;

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_RUN))
		else $error("divider finished outside run state");

	a_busy_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_RUN))
		else $error("divider busy outside run state");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == ST_RUN) && div_stat.busy)
		else $error("accepted limb did not start the divider");

	a_zero_div_out: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && zero_out_q) |-> ((quot_out_q == '0) && (rem_out_q == '0)
		&& !rem_nz_q && (len_q == '0)))
		else $error("zero divisor response carries data");

	a_nz_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rem_nz_q == (rem_out_q != '0)))
		else $error("remainder flag disagrees with remainder");

endmodule
